// ===== src/htfp_pkg.sv =====
// shared types and constants for the head/tail frame parser
package htfp_pkg;

  localparam int FRAME_BYTES         = 22;
  localparam int FILL_BITS           = $clog2(FRAME_BYTES + 1);
  localparam int COUNT_BITS_DEFAULT  = 32;
  localparam int OUT_BITS            = 32;

  // byte offsets of the payload words inside a frame
  localparam int OFS_PITCH      = 1;
  localparam int OFS_YAW        = 5;
  localparam int OFS_PITCH_RATE = 9;
  localparam int OFS_YAW_RATE   = 13;
  localparam int OFS_STAMP      = 17;

  // configuration register indexes
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  // item kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic [FRAME_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
    logic [31:0] pitch_rate_bits;
    logic [31:0] yaw_rate_bits;
    logic [31:0] stamp;
    logic [31:0] bytes_seen;
    logic [31:0] bytes_dropped;
    logic [31:0] frames_bad;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } win_ctrl_t;

  typedef struct packed {
    logic head_front;
    logic tail_end;
  } win_stat_t;

  typedef struct packed {
    logic                 clear;
    logic                 inc_total;
    logic                 inc_bad;
    logic                 add_drop;
    logic [FILL_BITS-1:0] drop_amt;
  } stat_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_RESULT
  } state_t;

endpackage

// ===== src/head_tail_frame_parser_unit.sv =====
// Head/tail byte frame synchronizer for fixed 22-byte frames.
// Input channel (in_valid/in_ready/in_data): one item per transfer, either a
// received byte or a request to clear the statistics counters.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// input item, carrying the frame words when a good frame completed and the
// three saturating counters after that item.
// Config port (cfg_we/cfg_index/cfg_data): head byte at index 0, tail byte at
// index 1; write only while the block is idle.
// Steps: a clear item goes straight to the result state; a byte that does
// not fill the window passes through the evaluate state to the result; a full
// window that holds a good frame does the same, and one that does not runs
// a head search in the scan state before the result. The window sits in a row
// of byte cells that rotates left one cell per cycle during the search.
// One item is worked on at a time; in_ready is high only while idle.
// The result sits in an output register, so the next item is taken while
// a result waits; a stalled receiver holds back only the following result.
// Reset empties the window, clears the counters and loads head 0xA5 and
// tail 0x5A. Window contents are not cleared.
module head_tail_frame_parser_unit #(
  parameter int COUNT_BITS = htfp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  htfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output htfp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import htfp_pkg::*;

  localparam logic [FILL_BITS-1:0] FULL = FILL_BITS'(FRAME_BYTES);

  state_t               state, state_next;
  logic [FILL_BITS-1:0] fill, fill_next;
  logic [FILL_BITS-1:0] scan_cnt, scan_cnt_next;
  logic                 bad_mode, bad_mode_next;
  logic                 frame_hit, frame_hit_next;
  logic [7:0]           head_byte, tail_byte;
  logic                 out_load;
  logic                 in_fire;

  win_ctrl_t  win_ctrl;
  win_stat_t  win_stat;
  window_t    win_bytes;
  stat_ctrl_t stat_ctrl;

  logic [31:0] bytes_seen, bytes_dropped, frames_bad;

  function automatic logic [31:0] le_word(window_t w, int at);
    return {w[at+3], w[at+2], w[at+1], w[at]};
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= 8'd165;
      tail_byte <= 8'd90;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD: head_byte <= cfg_data;
        REG_TAIL: tail_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_data.kind == KIND_CLEAR) ? S_RESULT : S_EVAL;
        end
      end
      S_EVAL: begin
        if (fill != FULL || (win_stat.head_front && win_stat.tail_end)) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == FULL || (win_stat.head_front && scan_cnt != '0)) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    win_ctrl       = '0;
    stat_ctrl      = '0;
    fill_next      = fill;
    scan_cnt_next  = scan_cnt;
    bad_mode_next  = bad_mode;
    frame_hit_next = frame_hit;
    out_load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        frame_hit_next = 1'b0;
        if (in_fire) begin
          if (in_data.kind == KIND_CLEAR) begin
            stat_ctrl.clear = 1'b1;
          end else begin
            win_ctrl.load       = 1'b1;
            stat_ctrl.inc_total = 1'b1;
            fill_next           = fill + 1'b1;
          end
        end
      end
      S_EVAL: begin
        scan_cnt_next = '0;
        if (fill == FULL) begin
          if (win_stat.head_front && win_stat.tail_end) begin
            frame_hit_next = 1'b1;
            fill_next      = '0;
          end else begin
            // head at the front with a wrong tail: bad frame, search past it
            bad_mode_next     = win_stat.head_front;
            stat_ctrl.inc_bad = win_stat.head_front;
          end
        end
      end
      S_SCAN: begin
        if (scan_cnt == FULL) begin
          // full turn without a head
          stat_ctrl.add_drop = 1'b1;
          if (bad_mode) begin
            stat_ctrl.drop_amt = FULL;
            fill_next          = '0;
          end else begin
            // one more turn puts the oldest byte past the end
            win_ctrl.rotate    = 1'b1;
            stat_ctrl.drop_amt = FILL_BITS'(1);
            fill_next          = FULL - 1'b1;
          end
        end else if (win_stat.head_front && scan_cnt != '0) begin
          // skipped bytes now sit behind the fill point
          stat_ctrl.add_drop = 1'b1;
          stat_ctrl.drop_amt = scan_cnt;
          fill_next          = FULL - scan_cnt;
        end else begin
          win_ctrl.rotate = 1'b1;
          scan_cnt_next   = scan_cnt + 1'b1;
        end
      end
      S_RESULT: begin
        out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      scan_cnt  <= '0;
      bad_mode  <= 1'b0;
      frame_hit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      scan_cnt  <= scan_cnt_next;
      bad_mode  <= bad_mode_next;
      frame_hit <= frame_hit_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.frame_valid     <= frame_hit;
      out_data.pitch_bits      <= frame_hit ? le_word(win_bytes, OFS_PITCH) : '0;
      out_data.yaw_bits        <= frame_hit ? le_word(win_bytes, OFS_YAW) : '0;
      out_data.pitch_rate_bits <= frame_hit ? le_word(win_bytes, OFS_PITCH_RATE) : '0;
      out_data.yaw_rate_bits   <= frame_hit ? le_word(win_bytes, OFS_YAW_RATE) : '0;
      out_data.stamp           <= frame_hit ? le_word(win_bytes, OFS_STAMP) : '0;
      out_data.bytes_seen      <= bytes_seen;
      out_data.bytes_dropped   <= bytes_dropped;
      out_data.frames_bad      <= frames_bad;
    end
  end

  htfp_window u_window (
    .clk       (clk),
    .ctrl      (win_ctrl),
    .fill      (fill),
    .rx_byte   (in_data.rx_byte),
    .head_byte (head_byte),
    .tail_byte (tail_byte),
    .stat      (win_stat),
    .bytes     (win_bytes)
  );

  htfp_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (stat_ctrl),
    .bytes_seen    (bytes_seen),
    .bytes_dropped (bytes_dropped),
    .frames_bad    (frames_bad)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("window fill beyond frame length");

  a_idle_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> fill != FULL)
    else $error("window full while waiting for a byte");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_cnt <= FULL)
    else $error("head search ran past a full turn");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_EVAL || state == S_RESULT)
    else $error("accepted item not taken up");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register not loaded");
`endif

endmodule

// ===== src/htfp_cell.sv =====
// one byte cell of the window row: parallel load or take the neighbor's byte
module htfp_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_byte,
  input  logic [7:0] shift_byte,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_byte;
    end else if (shift) begin
      q <= shift_byte;
    end
  end

endmodule

// ===== src/htfp_window.sv =====
// row of byte cells holding the receive window, rotating left one cell per cycle while rotate is set
module htfp_window (
  input  logic                      clk,
  input  htfp_pkg::win_ctrl_t       ctrl,
  input  logic [htfp_pkg::FILL_BITS-1:0] fill,
  input  logic [7:0]                rx_byte,
  input  logic [7:0]                head_byte,
  input  logic [7:0]                tail_byte,
  output htfp_pkg::win_stat_t       stat,
  output htfp_pkg::window_t         bytes
);
  import htfp_pkg::*;

  logic [7:0] cell_q [FRAME_BYTES];

  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    localparam int NEXT = (i + 1) % FRAME_BYTES;
    logic load_here;

    // new byte goes into the first free cell
    assign load_here = ctrl.load && (fill == FILL_BITS'(i));

    htfp_cell u_cell (
      .clk        (clk),
      .load       (load_here),
      .shift      (ctrl.rotate),
      .load_byte  (rx_byte),
      .shift_byte (cell_q[NEXT]),
      .q          (cell_q[i])
    );

    assign bytes[i] = cell_q[i];
  end

  assign stat.head_front = (cell_q[0] == head_byte);
  assign stat.tail_end   = (cell_q[FRAME_BYTES-1] == tail_byte);

endmodule

// ===== src/htfp_stats.sv =====
// saturating statistics counters: bytes seen, bytes dropped, bad frames
module htfp_stats #(
  parameter int COUNT_BITS = htfp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  htfp_pkg::stat_ctrl_t ctrl,
  output logic [31:0]          bytes_seen,
  output logic [31:0]          bytes_dropped,
  output logic [31:0]          frames_bad
);
  import htfp_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [COUNT_BITS:0]   ONE  = {{COUNT_BITS{1'b0}}, 1'b1};

  logic [COUNT_BITS-1:0] total_count, drop_count, bad_count;
  logic [COUNT_BITS-1:0] total_count_next, drop_count_next, bad_count_next;
  logic [COUNT_BITS:0]   total_sum, drop_sum, bad_sum;

  assign total_sum = {1'b0, total_count} + ONE;
  assign bad_sum   = {1'b0, bad_count} + ONE;
  assign drop_sum  = {1'b0, drop_count}
                   + {{(COUNT_BITS + 1 - FILL_BITS){1'b0}}, ctrl.drop_amt};

  always_comb begin
    total_count_next = total_count;
    drop_count_next  = drop_count;
    bad_count_next   = bad_count;
    if (ctrl.clear) begin
      total_count_next = '0;
      drop_count_next  = '0;
      bad_count_next   = '0;
    end else begin
      // carry out of the top bit means saturate
      if (ctrl.inc_total) begin
        total_count_next = total_sum[COUNT_BITS] ? CMAX : total_sum[COUNT_BITS-1:0];
      end
      if (ctrl.inc_bad) begin
        bad_count_next = bad_sum[COUNT_BITS] ? CMAX : bad_sum[COUNT_BITS-1:0];
      end
      if (ctrl.add_drop) begin
        drop_count_next = drop_sum[COUNT_BITS] ? CMAX : drop_sum[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      drop_count  <= '0;
      bad_count   <= '0;
    end else begin
      total_count <= total_count_next;
      drop_count  <= drop_count_next;
      bad_count   <= bad_count_next;
    end
  end

  assign bytes_seen    = OUT_BITS'(total_count);
  assign bytes_dropped = OUT_BITS'(drop_count);
  assign frames_bad    = OUT_BITS'(bad_count);

endmodule
